FILE: hdl/selection_sampling_draw_checker_macros.svh
// ----------------------------------------------------------------------------
// Selection sampling draw checker assertion macros
// Concurrent assertion shorthands shared by the checker RTL.
// ----------------------------------------------------------------------------
`ifndef SELECTION_SAMPLING_DRAW_CHECKER_MACROS_SVH
`define SELECTION_SAMPLING_DRAW_CHECKER_MACROS_SVH
`ifndef SYNTH
`define SDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");
`define SDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");
`else
`define SDS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/sds_pkg.sv
// ----------------------------------------------------------------------------
// Selection sampling draw checker package
// Shared types and constants for the checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

   localparam logic [2:0] KIND_XORSHIFT = 3'd0;
   localparam logic [2:0] KIND_MINSTD   = 3'd1;
   localparam logic [2:0] KIND_LCG31    = 3'd2;
   localparam logic [2:0] KIND_LCG15    = 3'd3;
   localparam logic [2:0] KIND_LCG48    = 3'd4;
   localparam logic [2:0] KIND_PCG      = 3'd5;

   localparam logic [2:0] REG_KIND = 3'd0;
   localparam logic [2:0] REG_SEED = 3'd1;
   localparam logic [2:0] REG_SKIP = 3'd2;
   localparam logic [2:0] REG_STOP = 3'd3;
   localparam logic [2:0] REG_CAP  = 3'd4;

   localparam logic [63:0] PCG_MUL    = 64'd6364136223846793005;
   localparam logic [63:0] PCG_INC    = 64'd1442695040888963407;
   localparam logic [63:0] LCG48_MUL  = 64'h5DEECE66D;
   localparam logic [63:0] LCG48_INC  = 64'hB;
   localparam logic [63:0] MASK48     = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] MINSTD_MUL = 64'd48271;
   localparam logic [31:0] MINSTD_MOD = 32'd2147483647;
   localparam logic [63:0] LCG31_MUL  = 64'd1103515245;
   localparam logic [31:0] LCG31_INC  = 32'd12345;
   localparam logic [63:0] LCG15_MUL  = 64'd214013;
   localparam logic [31:0] LCG15_INC  = 32'd2531011;
   localparam logic [63:0] SM_GOLD    = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] SM_MUL1    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] SM_MUL2    = 64'h94D049BB133111EB;

   localparam logic [15:0] CAP_RESET = 16'd8;

   typedef struct packed {
      logic [2:0]  generator_kind;
      logic [31:0] start_seed;
      logic [7:0]  lead_skip;
      logic        stop_mode;
      logic [15:0] draw_cap;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic        draw_matched;
      logic [15:0] run_length;
      logic        broken;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/sds_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier unit
// Forms a 64 by 64 product from three 32 by 32 partial products in turn;
// the low 64 bits are exact, and all 96 bits when op_b fits 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sds_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sds_pkg::mul_req_type mul_req,
   output logic                    mul_done,
   output logic [95:0]             mul_product
);

   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [95:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] mul_x, mul_y;

   always_comb begin
      case (cnt_ff)
         2'd0: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         2'd1: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
         default: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.op_a;
         b_in    = mul_req.op_b;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = mul_x * mul_y;
         cnt_in  = cnt_ff + 2'd1;
         case (cnt_ff)
            2'd0: begin
            end
            2'd1: begin
               acc_in = {32'b0, prod_ff};
            end
            2'd2: begin
               acc_in = acc_ff + {prod_ff, 32'b0};
            end
            default: begin
               acc_in  = acc_ff + {prod_ff, 32'b0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_done    = done_ff;
   assign mul_product = acc_ff;

endmodule
`default_nettype wire

FILE: hdl/sds_seq.sv
// ----------------------------------------------------------------------------
// Draw sequencer
// Seeds and steps the generator, runs selection sampling candidate by
// candidate on the shared multiplier and scores each draw.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sds_seq #(
   parameter int POOL_SIZE  = 80,
   parameter int PICK_COUNT = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sds_pkg::cfg_type      cfg,
   input  wire logic                  item_start,
   input  wire logic                  item_action,
   input  wire logic [79:0]           item_chosen,
   output logic                       seq_idle,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output sds_pkg::result_type        res,
   output sds_pkg::mul_req_type       mul_req,
   input  wire logic                  mul_done,
   input  wire logic [95:0]           mul_product
);

   localparam int MAXN = (POOL_SIZE > PICK_COUNT) ? POOL_SIZE : PICK_COUNT;
   localparam int CW   = $clog2(MAXN + 1);

   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_DRAW = 2'd1;
   localparam logic [1:0] PH_BURN = 2'd2;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_SEED    = 10'b0000000010,
      ST_SEEDMUL = 10'b0000000100,
      ST_GEN     = 10'b0000001000,
      ST_MULA    = 10'b0000010000,
      ST_MULB    = 10'b0000100000,
      ST_POST    = 10'b0001000000,
      ST_CMP     = 10'b0010000000,
      ST_FINISH  = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } seq_state_type;

   function automatic logic [31:0] xorshift32(input logic [31:0] x);
      logic [31:0] v;
      v = x ^ (x << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   function automatic logic [31:0] pcg_out(input logic [63:0] o);
      logic [31:0] xs;
      logic [63:0] rot;
      xs  = 32'(((o >> 18) ^ o) >> 27);
      rot = {xs, xs} >> o[63:59];
      return rot[31:0];
   endfunction

   seq_state_type        state_ff, state_in;
   logic [63:0]          gen_ff, gen_in, u_ff, u_in;
   logic [1:0]           phase_ff, phase_in;
   logic [7:0]           skip_ff, skip_in;
   logic [CW-1:0]        t_ff, t_in, m_ff, m_in;
   logic [79:0]          sel_ff, sel_in, obs_ff, obs_in;
   logic [15:0]          run_ff, run_in;
   logic                 broken_ff, broken_in;
   sds_pkg::result_type  res_ff, res_in;

   logic [63:0] p64, sm_z, seed_val, a72_src;
   logic [31:0] xs_val, minstd_sum, minstd_red, lcg31_s, lcg15_s, seed_m;
   logic [71:0] lhs, rhs, a72;
   logic [CW:0] bfac;
   logic [16:0] run_inc;
   logic        below, last_t, draw_match;

   assign p64        = mul_product[63:0];
   assign xs_val     = xorshift32(gen_ff[31:0]);
   assign sm_z       = gen_ff + sds_pkg::SM_GOLD;
   assign minstd_sum = {1'b0, p64[30:0]} + {15'b0, p64[47:31]};
   assign minstd_red = (minstd_sum >= sds_pkg::MINSTD_MOD) ?
                       minstd_sum - sds_pkg::MINSTD_MOD : minstd_sum;
   assign lcg31_s    = p64[31:0] + sds_pkg::LCG31_INC;
   assign lcg15_s    = p64[31:0] + sds_pkg::LCG15_INC;
   assign bfac       = (CW + 1)'(POOL_SIZE + 1) - {1'b0, t_ff};
   assign last_t     = (t_ff == CW'(POOL_SIZE));
   assign lhs        = mul_product[71:0];
   assign a72        = 72'(CW'(PICK_COUNT) - m_ff);
   assign a72_src    = 64'(a72);
   assign below      = (lhs < rhs);
   assign run_inc    = {1'b0, run_ff} + 17'd1;
   assign draw_match = (m_ff == CW'(PICK_COUNT)) && (sel_ff == obs_ff);

   always_comb begin
      if (cfg.start_seed >= {sds_pkg::MINSTD_MOD[30:0], 1'b0}) begin
         seed_m = cfg.start_seed - {sds_pkg::MINSTD_MOD[30:0], 1'b0};
      end else if (cfg.start_seed >= sds_pkg::MINSTD_MOD) begin
         seed_m = cfg.start_seed - sds_pkg::MINSTD_MOD;
      end else begin
         seed_m = cfg.start_seed;
      end
      case (cfg.generator_kind)
         sds_pkg::KIND_XORSHIFT: begin
            seed_val = {32'b0, (cfg.start_seed == 32'b0) ? 32'd1 : cfg.start_seed};
         end
         sds_pkg::KIND_MINSTD: begin
            seed_val = {32'b0, (seed_m == 32'b0) ? 32'd1 : seed_m};
         end
         sds_pkg::KIND_LCG48: begin
            seed_val = ({32'b0, cfg.start_seed} ^ sds_pkg::LCG48_MUL) & sds_pkg::MASK48;
         end
         default: begin
            seed_val = {32'b0, cfg.start_seed};
         end
      endcase
   end

   always_comb begin
      case (cfg.generator_kind)
         sds_pkg::KIND_XORSHIFT, sds_pkg::KIND_LCG48, sds_pkg::KIND_PCG: begin
            rhs = a72 << 32;
         end
         sds_pkg::KIND_MINSTD: begin
            rhs = (a72 << 31) - a72;
         end
         sds_pkg::KIND_LCG31: begin
            rhs = a72 << 31;
         end
         sds_pkg::KIND_LCG15: begin
            rhs = a72 << 15;
         end
         default: begin
            rhs = {a72_src[7:0], 64'b0};
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      gen_in    = gen_ff;
      u_in      = u_ff;
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      t_in      = t_ff;
      m_in      = m_ff;
      sel_in    = sel_ff;
      obs_in    = obs_ff;
      run_in    = run_ff;
      broken_in = broken_ff;
      res_in    = res_ff;
      mul_req   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (item_start) begin
               obs_in = item_chosen;
               if (!item_action) begin
                  state_in = ST_SEED;
               end else if (broken_ff) begin
                  res_in   = '{draw_matched: 1'b0, run_length: run_ff, broken: 1'b1};
                  state_in = ST_OUT;
               end else begin
                  t_in     = CW'(1);
                  m_in     = '0;
                  sel_in   = '0;
                  phase_in = PH_DRAW;
                  state_in = ST_GEN;
               end
            end
         end
         ST_SEED: begin
            run_in    = '0;
            broken_in = 1'b0;
            skip_in   = cfg.lead_skip;
            phase_in  = PH_SKIP;
            res_in    = '0;
            if (cfg.generator_kind == sds_pkg::KIND_PCG) begin
               mul_req  = '{start: 1'b1,
                            op_a: sds_pkg::PCG_INC + {32'b0, cfg.start_seed},
                            op_b: sds_pkg::PCG_MUL};
               state_in = ST_SEEDMUL;
            end else begin
               gen_in   = seed_val;
               state_in = (cfg.lead_skip == 8'd0) ? ST_OUT : ST_GEN;
            end
         end
         ST_SEEDMUL: begin
            if (mul_done) begin
               gen_in   = p64 + sds_pkg::PCG_INC;
               state_in = (skip_ff == 8'd0) ? ST_OUT : ST_GEN;
            end
         end
         ST_GEN: begin
            state_in = ST_MULA;
            case (cfg.generator_kind)
               sds_pkg::KIND_XORSHIFT: begin
                  gen_in   = {32'b0, xs_val};
                  u_in     = {32'b0, xs_val};
                  state_in = ST_POST;
               end
               sds_pkg::KIND_MINSTD: begin
                  mul_req = '{start: 1'b1, op_a: {32'b0, gen_ff[31:0]},
                              op_b: sds_pkg::MINSTD_MUL};
               end
               sds_pkg::KIND_LCG31: begin
                  mul_req = '{start: 1'b1, op_a: {32'b0, gen_ff[31:0]},
                              op_b: sds_pkg::LCG31_MUL};
               end
               sds_pkg::KIND_LCG15: begin
                  mul_req = '{start: 1'b1, op_a: {32'b0, gen_ff[31:0]},
                              op_b: sds_pkg::LCG15_MUL};
               end
               sds_pkg::KIND_LCG48: begin
                  mul_req = '{start: 1'b1, op_a: gen_ff, op_b: sds_pkg::LCG48_MUL};
               end
               sds_pkg::KIND_PCG: begin
                  u_in    = {32'b0, pcg_out(gen_ff)};
                  mul_req = '{start: 1'b1, op_a: gen_ff, op_b: sds_pkg::PCG_MUL};
               end
               default: begin
                  gen_in  = sm_z;
                  mul_req = '{start: 1'b1, op_a: sm_z ^ (sm_z >> 30),
                              op_b: sds_pkg::SM_MUL1};
               end
            endcase
         end
         ST_MULA: begin
            if (mul_done) begin
               state_in = ST_POST;
               case (cfg.generator_kind)
                  sds_pkg::KIND_MINSTD: begin
                     gen_in = {32'b0, minstd_red};
                     u_in   = {32'b0, minstd_red};
                  end
                  sds_pkg::KIND_LCG31: begin
                     gen_in = {32'b0, lcg31_s};
                     u_in   = {33'b0, lcg31_s[31:1]};
                  end
                  sds_pkg::KIND_LCG15: begin
                     gen_in = {32'b0, lcg15_s};
                     u_in   = {49'b0, lcg15_s[30:16]};
                  end
                  sds_pkg::KIND_LCG48: begin
                     gen_in = (p64 + sds_pkg::LCG48_INC) & sds_pkg::MASK48;
                     u_in   = ((p64 + sds_pkg::LCG48_INC) & sds_pkg::MASK48) >> 16;
                  end
                  sds_pkg::KIND_PCG: begin
                     gen_in = p64 + sds_pkg::PCG_INC;
                  end
                  default: begin
                     mul_req  = '{start: 1'b1, op_a: p64 ^ (p64 >> 27),
                                  op_b: sds_pkg::SM_MUL2};
                     state_in = ST_MULB;
                  end
               endcase
            end
         end
         ST_MULB: begin
            if (mul_done) begin
               u_in     = p64 ^ (p64 >> 31);
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            case (phase_ff)
               PH_SKIP: begin
                  skip_in  = skip_ff - 8'd1;
                  state_in = (skip_ff == 8'd1) ? ST_OUT : ST_GEN;
               end
               PH_DRAW: begin
                  mul_req  = '{start: 1'b1, op_a: u_ff, op_b: 64'(bfac)};
                  state_in = ST_CMP;
               end
               default: begin
                  if (last_t) begin
                     state_in = ST_FINISH;
                  end else begin
                     t_in     = t_ff + CW'(1);
                     state_in = ST_GEN;
                  end
               end
            endcase
         end
         ST_CMP: begin
            if (mul_done) begin
               if (below) begin
                  sel_in[7'(t_ff - CW'(1))] = 1'b1;
                  m_in = m_ff + CW'(1);
               end
               if (below && (m_ff + CW'(1) == CW'(PICK_COUNT))) begin
                  if (cfg.stop_mode && !last_t) begin
                     phase_in = PH_BURN;
                     t_in     = t_ff + CW'(1);
                     state_in = ST_GEN;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else if (last_t) begin
                  state_in = ST_FINISH;
               end else begin
                  t_in     = t_ff + CW'(1);
                  state_in = ST_GEN;
               end
            end
         end
         ST_FINISH: begin
            if (draw_match) begin
               run_in = (run_inc > {1'b0, cfg.draw_cap}) ? cfg.draw_cap : run_inc[15:0];
               res_in = '{draw_matched: 1'b1, run_length: run_in, broken: 1'b0};
            end else begin
               broken_in = 1'b1;
               res_in    = '{draw_matched: 1'b0, run_length: run_ff, broken: 1'b1};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      gen_ff   <= gen_in;
      u_ff     <= u_in;
      phase_ff <= phase_in;
      skip_ff  <= skip_in;
      t_ff     <= t_in;
      m_ff     <= m_in;
      sel_ff   <= sel_in;
      obs_ff   <= obs_in;
      res_ff   <= res_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         gen_ff    <= '0;
         run_ff    <= '0;
         broken_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         run_ff    <= run_in;
         broken_ff <= broken_in;
      end
   end

   assign seq_idle  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_OUT);
   assign res       = res_ff;

endmodule
`default_nettype wire

FILE: hdl/selection_sampling_draw_checker.sv
// ----------------------------------------------------------------------------
// Selection sampling draw checker
// Replays a seeded generator through selection sampling and checks draws.
// ----------------------------------------------------------------------------
// One item is taken at a time and req_tready stays low until its result has
// moved into the output register. A restart seeds the generator and then takes
// one generator step per lead output skipped. A draw takes one generator step
// and one threshold compare per pool candidate until all picks are made, and in
// stop mode a generator step for each candidate left. xorshift32 needs no
// generator product, the LCG, MINSTD and PCG kinds need one and splitmix64 two.
// A draw arriving while broken skips sampling and goes from idle straight to the
// output state. Draw time is set by the single 32 by 32 multiplier, which forms
// each wide product from three partial products in turn.
`timescale 1ns / 1ps
`default_nettype none
`include "selection_sampling_draw_checker_macros.svh"
module selection_sampling_draw_checker #(
   parameter int POOL_SIZE  = 80,
   parameter int PICK_COUNT = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // chosen_low [63:0], chosen_high [79:64]
   input  wire logic        req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // draw_matched [0], run_length [16:1],
                                        // broken [17], zero [23:18]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   sds_pkg::cfg_type      cfg_ff, cfg_in;
   sds_pkg::mul_req_type  mul_req;
   sds_pkg::result_type   res;
   logic                  mul_done, seq_idle, res_valid, res_ready;
   logic [95:0]           mul_product;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sds_pkg::REG_KIND: cfg_in.generator_kind = csr_data[2:0];
            sds_pkg::REG_SEED: cfg_in.start_seed     = csr_data;
            sds_pkg::REG_SKIP: cfg_in.lead_skip      = csr_data[7:0];
            sds_pkg::REG_STOP: cfg_in.stop_mode      = csr_data[0];
            sds_pkg::REG_CAP:  cfg_in.draw_cap       = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, res.broken, res.run_length, res.draw_matched};
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         cfg_ff       <= '{generator_kind: sds_pkg::KIND_XORSHIFT, start_seed: 32'd0,
                           lead_skip: 8'd0, stop_mode: 1'b0, draw_cap: sds_pkg::CAP_RESET};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   sds_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_req     (mul_req),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   sds_seq #(
      .POOL_SIZE  (POOL_SIZE),
      .PICK_COUNT (PICK_COUNT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_start  (req_tvalid && req_tready),
      .item_action (req_tuser),
      .item_chosen (req_tdata),
      .seq_idle    (seq_idle),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mul_req     (mul_req),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   assign req_tready = seq_idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SDS_ASSERT_IMP(a_match_not_broken, clock, reset, rsp_tvalid && rsp_tdata[0], !rsp_tdata[17])
   `SDS_ASSERT_IMP(a_run_within_cap, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[16:1] <= cfg_ff.draw_cap)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Selection sampling draw checker testbench
// Drives restart and draw transfers into the checker, with register writes
// between phases, and compares every result transfer against a typed result or
// a cycle-free model of the seeded generators and selection sampling procedure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam int POOL  = 80;
   localparam int PICKS = 20;
   localparam logic [2:0] KIND_SPLITMIX = 3'd6;
   localparam logic ACT_RESTART = 1'b0;
   localparam logic ACT_DRAW    = 1'b1;
   localparam int TARGET_ITEMS = 800;
   localparam longint CYCLE_LIMIT = 20000000;

   typedef enum logic [1:0] {SRC_GIVEN, SRC_TRUE, SRC_FLIP} mask_src_type;

   typedef struct {
      logic                 action;
      mask_src_type         src;
      logic [79:0]          mask;
      logic                 typed;
      sds_pkg::result_type  res;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   sds_pkg::cfg_type     shadow_cfg;
   logic [63:0]          gen_state;
   logic [15:0]          run_count;
   logic                 broken_flag;
   sds_pkg::result_type  pending_results[$];
   int                   error_count;
   longint               cycle_count;
   int                   stall_left;

   selection_sampling_draw_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] gen_next(inout logic [63:0] st, input logic [2:0] kind);
      logic [31:0] x;
      logic [31:0] xs;
      logic [4:0]  rot;
      logic [63:0] o;
      logic [63:0] z;
      x = st[31:0];
      case (kind)
         sds_pkg::KIND_XORSHIFT: begin
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            st = {32'd0, x};
            return st;
         end
         sds_pkg::KIND_MINSTD: begin
            st = ({32'd0, x} * sds_pkg::MINSTD_MUL) % {32'd0, sds_pkg::MINSTD_MOD};
            return st;
         end
         sds_pkg::KIND_LCG31: begin
            x = x * sds_pkg::LCG31_MUL[31:0] + sds_pkg::LCG31_INC;
            st = {32'd0, x};
            return {33'd0, x[31:1]};
         end
         sds_pkg::KIND_LCG15: begin
            x = x * sds_pkg::LCG15_MUL[31:0] + sds_pkg::LCG15_INC;
            st = {32'd0, x};
            return {49'd0, x[30:16]};
         end
         sds_pkg::KIND_LCG48: begin
            st = (st * sds_pkg::LCG48_MUL + sds_pkg::LCG48_INC) & sds_pkg::MASK48;
            return st >> 16;
         end
         sds_pkg::KIND_PCG: begin
            o = st;
            st = o * sds_pkg::PCG_MUL + sds_pkg::PCG_INC;
            z = ((o >> 18) ^ o) >> 27;
            xs = z[31:0];
            rot = o[63:59];
            return {32'd0, (xs >> rot) | (xs << (5'd0 - rot))};
         end
         default: begin
            st = st + sds_pkg::SM_GOLD;
            z = st;
            z = (z ^ (z >> 30)) * sds_pkg::SM_MUL1;
            z = (z ^ (z >> 27)) * sds_pkg::SM_MUL2;
            return z ^ (z >> 31);
         end
      endcase
   endfunction

   function automatic logic [63:0] seeded_state(input logic [2:0] kind, input logic [31:0] seed);
      logic [63:0] st;
      case (kind)
         sds_pkg::KIND_XORSHIFT: st = (seed == 32'd0) ? 64'd1 : {32'd0, seed};
         sds_pkg::KIND_MINSTD: begin
            st = {32'd0, seed % sds_pkg::MINSTD_MOD};
            if (st == 64'd0) st = 64'd1;
         end
         sds_pkg::KIND_LCG31, sds_pkg::KIND_LCG15: st = {32'd0, seed};
         sds_pkg::KIND_LCG48: st = ({32'd0, seed} ^ sds_pkg::LCG48_MUL) & sds_pkg::MASK48;
         sds_pkg::KIND_PCG:
            st = (sds_pkg::PCG_INC + {32'd0, seed}) * sds_pkg::PCG_MUL + sds_pkg::PCG_INC;
         default: st = {32'd0, seed};
      endcase
      return st;
   endfunction

   function automatic logic below_threshold(input logic [63:0] u, input int picks_left,
                                            input int pool_left, input logic [2:0] kind);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] a;
      a = 128'(picks_left);
      lhs = {64'd0, u} * 128'(pool_left);
      case (kind)
         sds_pkg::KIND_XORSHIFT, sds_pkg::KIND_LCG48, sds_pkg::KIND_PCG: rhs = a << 32;
         sds_pkg::KIND_MINSTD: rhs = a * 128'(sds_pkg::MINSTD_MOD);
         sds_pkg::KIND_LCG31: rhs = a << 31;
         sds_pkg::KIND_LCG15: rhs = a << 15;
         default: rhs = a << 64;
      endcase
      return lhs < rhs;
   endfunction

   // Runs one selection over the pool; true when all picks were made.
   function automatic logic sample_pool(inout logic [63:0] st, output logic [79:0] sel);
      int made;
      logic [63:0] u;
      made = 0;
      sel = '0;
      for (int t = 1; t <= POOL; t++) begin
         u = gen_next(st, shadow_cfg.generator_kind);
         if (below_threshold(u, PICKS - made, POOL - t + 1, shadow_cfg.generator_kind)) begin
            sel[t-1] = 1'b1;
            made++;
            if (made == PICKS) begin
               if (shadow_cfg.stop_mode)
                  for (int q = t + 1; q <= POOL; q++) u = gen_next(st, shadow_cfg.generator_kind);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [79:0] true_mask();
      logic [63:0] st;
      logic [79:0] sel;
      st = gen_state;
      void'(sample_pool(st, sel));
      return sel;
   endfunction

   function automatic sds_pkg::result_type predict_checker(input logic action,
                                                           input logic [79:0] mask);
      sds_pkg::result_type r;
      logic [79:0] sel;
      logic [63:0] u;
      logic [16:0] next_run;
      logic        full;
      if (action == ACT_RESTART) begin
         gen_state = seeded_state(shadow_cfg.generator_kind, shadow_cfg.start_seed);
         for (int i = 0; i < shadow_cfg.lead_skip; i++)
            u = gen_next(gen_state, shadow_cfg.generator_kind);
         run_count = '0;
         broken_flag = 1'b0;
         r.draw_matched = 1'b0;
      end else if (!broken_flag) begin
         full = sample_pool(gen_state, sel);
         if (full && sel == mask) begin
            next_run = {1'b0, run_count} + 17'd1;
            if (next_run > {1'b0, shadow_cfg.draw_cap}) next_run = {1'b0, shadow_cfg.draw_cap};
            run_count = next_run[15:0];
            r.draw_matched = 1'b1;
         end else begin
            broken_flag = 1'b1;
            r.draw_matched = 1'b0;
         end
      end else begin
         r.draw_matched = 1'b0;
      end
      r.run_length = run_count;
      r.broken = broken_flag;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint exp_val, input longint got_val);
      $display("MISMATCH %s: expected %0d, got %0d at cycle %0d", what, exp_val, got_val,
               cycle_count);
      error_count++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(input logic action, input logic [79:0] mask, input logic typed,
                            input sds_pkg::result_type typed_res);
      sds_pkg::result_type r;
      int gap;
      r = predict_checker(action, mask);
      pending_results.push_back(typed ? typed_res : r);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= mask;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sds_pkg::REG_KIND: shadow_cfg.generator_kind = value[2:0];
         sds_pkg::REG_SEED: shadow_cfg.start_seed = value;
         sds_pkg::REG_SKIP: shadow_cfg.lead_skip = value[7:0];
         sds_pkg::REG_STOP: shadow_cfg.stop_mode = value[0];
         sds_pkg::REG_CAP:  shadow_cfg.draw_cap = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [79:0] flip_one(input logic [79:0] m);
      m[$urandom_range(0, 79)] ^= 1'b1;
      return m;
   endfunction

   function automatic logic [79:0] random_mask();
      return {16'($urandom), $urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result transfer", 0, 1);
            end else begin
               sds_pkg::result_type e;
               e = pending_results.pop_front();
               if (rsp_tdata[0] !== e.draw_matched)
                  report_mismatch("draw_matched", e.draw_matched, rsp_tdata[0]);
               if (rsp_tdata[16:1] !== e.run_length)
                  report_mismatch("run_length", e.run_length, rsp_tdata[16:1]);
               if (rsp_tdata[17] !== e.broken)
                  report_mismatch("broken", e.broken, rsp_tdata[17]);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      dir_row_type          rows[20];
      sds_pkg::result_type  none;
      logic [79:0]          m;
      int                   item_count;
      int                   phase;
      int                   len;
      int                   roll;
      none = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      error_count = 0;
      cycle_count = 0;
      shadow_cfg = '{generator_kind: sds_pkg::KIND_XORSHIFT, start_seed: 32'd0,
                     lead_skip: 8'd0, stop_mode: 1'b0, draw_cap: sds_pkg::CAP_RESET};
      gen_state = '0;
      run_count = '0;
      broken_flag = 1'b0;

      rows[0]  = '{ACT_DRAW,    SRC_TRUE,  '0, 1'b0, none};
      rows[1]  = '{ACT_RESTART, SRC_GIVEN, '1, 1'b1, '{1'b0, 16'd0, 1'b0}};
      rows[2]  = '{ACT_DRAW,    SRC_TRUE,  '0, 1'b1, '{1'b1, 16'd1, 1'b0}};
      rows[3]  = '{ACT_DRAW,    SRC_TRUE,  '0, 1'b1, '{1'b1, 16'd2, 1'b0}};
      rows[4]  = '{ACT_DRAW,    SRC_FLIP,  '0, 1'b1, '{1'b0, 16'd2, 1'b1}};
      rows[5]  = '{ACT_DRAW,    SRC_GIVEN, '1, 1'b1, '{1'b0, 16'd2, 1'b1}};
      rows[6]  = '{ACT_RESTART, SRC_GIVEN, '0, 1'b1, '{1'b0, 16'd0, 1'b0}};
      rows[7]  = '{ACT_DRAW,    SRC_GIVEN, '0, 1'b1, '{1'b0, 16'd0, 1'b1}};
      rows[8]  = '{ACT_RESTART, SRC_GIVEN, {16'hFFFF, 64'd0}, 1'b1, '{1'b0, 16'd0, 1'b0}};
      for (int i = 9; i < 19; i++) rows[i] = '{ACT_DRAW, SRC_TRUE, '0, 1'b0, none};
      rows[19] = '{ACT_DRAW,    SRC_GIVEN, {16'hFFFF, 64'd0}, 1'b1, '{1'b0, 16'd8, 1'b1}};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         case (rows[i].src)
            SRC_TRUE: m = true_mask();
            SRC_FLIP: m = flip_one(true_mask());
            default:  m = rows[i].mask;
         endcase
         send_item(rows[i].action, m, rows[i].typed, rows[i].res);
      end

      item_count = 0;
      phase = 0;
      while (item_count < TARGET_ITEMS) begin
         wait_idle();
         if (phase == 0) begin
            write_reg(sds_pkg::REG_KIND, {29'd0, KIND_SPLITMIX});
            write_reg(sds_pkg::REG_SEED, 32'hFFFF_FFFF);
            write_reg(sds_pkg::REG_SKIP, 32'd255);
            write_reg(sds_pkg::REG_STOP, 32'd1);
            write_reg(sds_pkg::REG_CAP, 32'd65535);
         end else if (phase == 1) begin
            write_reg(sds_pkg::REG_KIND, {29'd0, sds_pkg::KIND_MINSTD});
            write_reg(sds_pkg::REG_SEED, {1'b0, 31'h7FFF_FFFF});
            write_reg(sds_pkg::REG_SKIP, 32'd0);
            write_reg(sds_pkg::REG_STOP, 32'd0);
            write_reg(sds_pkg::REG_CAP, 32'd0);
         end else begin
            write_reg(sds_pkg::REG_KIND, {29'd0, 3'($urandom_range(0, 7))});
            if ($urandom_range(0, 3) != 0) begin
               roll = $urandom_range(0, 5);
               write_reg(sds_pkg::REG_SEED,
                         roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF_FFFF : $urandom);
            end
            if ($urandom_range(0, 2) != 0)
               write_reg(sds_pkg::REG_SKIP,
                         $urandom_range(0, 3) == 0 ? 32'd255 : $urandom_range(0, 20));
            if ($urandom_range(0, 1) != 0) write_reg(sds_pkg::REG_STOP, $urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0) begin
               roll = $urandom_range(0, 5);
               write_reg(sds_pkg::REG_CAP, roll == 0 ? 32'd0 : roll == 1 ? 32'd65535 :
                                           $urandom_range(1, 12));
            end
         end
         if (phase < 2 || $urandom_range(0, 7) != 0) begin
            send_item(ACT_RESTART, random_mask(), 1'b0, none);
            item_count++;
         end
         len = $urandom_range(10, 25);
         for (int k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
               send_item(ACT_DRAW, true_mask(), 1'b0, none);
            end else if (roll < 88) begin
               send_item(ACT_DRAW, flip_one(true_mask()), 1'b0, none);
            end else if (roll < 94) begin
               send_item(ACT_DRAW, random_mask(), 1'b0, none);
            end else begin
               send_item(ACT_RESTART, random_mask(), 1'b0, none);
            end
            item_count++;
         end
         phase++;
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
